### rtl/core/ffra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants of the first-fit region allocator
// Request and response payloads, table entry layout, operation, status and
// register codes, and the status bundle of the table scan unit.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int unsigned DATA_W          = 16;
    localparam int unsigned CUR_W           = DATA_W + 1;
    localparam int unsigned MAX_REGIONS_DEF = 16;

    localparam logic [DATA_W-1:0] MEMORY_SIZE_RST = 16'd4096;
    localparam logic [DATA_W-1:0] HEAP_START_RST  = 16'd257;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_RESIZE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } t_status;

    typedef enum logic {
        CFG_MEMORY_SIZE = 1'b0,
        CFG_HEAP_START  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        SCAN_LOOKUP = 1'b0,
        SCAN_FIT    = 1'b1
    } t_scan_mode;

    typedef struct packed {
        t_op               operation;
        logic [DATA_W-1:0] request_size;
        logic [DATA_W-1:0] region_address;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        t_status           status;
    } t_rsp;

    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
    } t_entry;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] old_len;
        logic [CUR_W-1:0]  cur;
        logic              tail_ok;
        logic [DATA_W-1:0] space;
    } t_scan_stat;

endpackage : ffra_pkg
`default_nettype wire

### rtl/core/ffra_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_scan: per-entry evaluation of a table scan
// Takes one table entry per cycle and tracks the lookup results (first exact
// start match, first start above the address) or the first-fit cursor.
// ----------------------------------------------------------------------------
module ffra_scan
    import ffra_pkg::*;
#(
    parameter int unsigned IDX_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_init,
    input  wire t_scan_mode        i_mode,
    input  wire logic [DATA_W-1:0] i_heap_start,
    input  wire logic [DATA_W-1:0] i_memory_size,
    input  wire logic [DATA_W-1:0] i_size,
    input  wire logic [DATA_W-1:0] i_addr,
    input  wire logic              i_ev_valid,
    input  wire logic [IDX_W-1:0]  i_ev_idx,
    input  wire t_entry            i_ev_entry,
    output logic                   o_fit_hit,
    output logic [IDX_W-1:0]       o_pos,
    output t_scan_stat             o_stat
);

    logic              r_found;
    logic              r_gt_found;
    logic [IDX_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_old_len;
    logic [DATA_W-1:0] r_gt_start;
    logic [CUR_W-1:0]  r_cur;

    logic [CUR_W-1:0]  ev_start;
    logic [CUR_W-1:0]  ev_end;
    logic [CUR_W-1:0]  fit_gap;
    logic [CUR_W-1:0]  mem_ext;
    logic              lookup_ev;
    logic              fit_ev;

    always_comb begin
        ev_start  = {1'b0, i_ev_entry.start};
        ev_end    = ev_start + {1'b0, i_ev_entry.length};
        fit_gap   = ev_start - r_cur;
        mem_ext   = {1'b0, i_memory_size};
        lookup_ev = i_ev_valid && (i_mode == SCAN_LOOKUP);
        fit_ev    = i_ev_valid && (i_mode == SCAN_FIT);
        o_fit_hit = fit_ev && (ev_start >= r_cur) && (fit_gap >= {1'b0, i_size});

        o_pos          = r_pos;
        o_stat.found   = r_found;
        o_stat.old_len = r_old_len;
        o_stat.cur     = r_cur;
        o_stat.tail_ok = (mem_ext >= r_cur) && ((mem_ext - r_cur) >= {1'b0, i_size});
        if (i_addr > i_memory_size) begin
            o_stat.space = '0;
        end else if (r_gt_found) begin
            o_stat.space = r_gt_start - i_addr;
        end else begin
            o_stat.space = i_memory_size - i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_gt_found <= 1'b0;
        end else if (i_init) begin
            r_found    <= 1'b0;
            r_gt_found <= 1'b0;
        end else if (lookup_ev) begin
            if (!r_found && (i_ev_entry.start == i_addr)) begin
                r_found <= 1'b1;
            end
            if (!r_gt_found && (i_ev_entry.start > i_addr)) begin
                r_gt_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_cur <= {1'b0, i_heap_start};
        end else if (fit_ev && !o_fit_hit && (ev_end > r_cur)) begin
            // The cursor only moves forward, to the highest region end seen.
            r_cur <= ev_end;
        end
        if (lookup_ev && !r_found && (i_ev_entry.start == i_addr)) begin
            r_pos     <= i_ev_idx;
            r_old_len <= i_ev_entry.length;
        end
        if (lookup_ev && !r_gt_found && (i_ev_entry.start > i_addr)) begin
            r_gt_start <= i_ev_entry.start;
        end
    end

endmodule : ffra_scan
`default_nettype wire

### rtl/core/first_fit_region_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core: first-fit allocator over a sorted table
// Keeps up to MAX_REGIONS regions (start, length) in a one-port-read,
// one-port-write table memory and serves allocate, release, query and resize.
// ----------------------------------------------------------------------------
// The block handles one request at a time; its time is set by the table
// memory, which delivers one entry per cycle. A query scans the valid
// regions, an allocate runs the first-fit scan and then opens a slot, a
// release looks up the region and then closes the gap, and a resize that
// has to move looks it up, closes the gap, scans for a first fit and opens
// a slot. The result sits in an output register, so the next request is
// taken while a finished result still waits. No clearing pass is needed
// after reset: only entries below the region count are ever read.
module first_fit_region_allocator_core
    import ffra_pkg::*;
#(
    parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_req              i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_rsp                   o_out_rsp,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire t_cfg_idx          i_cfg_index,
    input  wire logic [DATA_W-1:0] i_cfg_data
);

    localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_SHUP = 5'b00100,
        S_SHDN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    t_scan_mode        r_mode, n_mode;
    t_req              r_req, n_req;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_dv, n_dv;
    logic [IW-1:0]     r_didx, n_didx;
    logic [IW-1:0]     r_ins_pos, n_ins_pos;
    logic [DATA_W-1:0] r_ins_start, n_ins_start;
    logic [DATA_W-1:0] r_ins_len, n_ins_len;
    logic [IW-1:0]     r_del_pos, n_del_pos;
    logic [DATA_W-1:0] r_old_len, n_old_len;
    t_rsp              r_res, n_res;
    t_rsp              r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_memory_size;
    logic [DATA_W-1:0] r_heap_start;

    t_entry            mem [0:MAX_REGIONS-1];
    t_entry            r_rd_data;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    t_entry            wr_data;

    logic              in_accept;
    logic              scan_init;
    logic              ev_valid;
    logic              fit_hit;
    logic [IW-1:0]     scan_pos;
    t_scan_stat        stat;
    logic [CW-1:0]     idx_dec;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign o_cfg_ready = 1'b1;
    assign ev_valid    = (r_state == S_SCAN) && r_dv;
    assign idx_dec     = r_idx - 1'b1;

    ffra_scan #(
        .IDX_W (IW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_init        (scan_init),
        .i_mode        (r_mode),
        .i_heap_start  (r_heap_start),
        .i_memory_size (r_memory_size),
        .i_size        (r_req.request_size),
        .i_addr        (r_req.region_address),
        .i_ev_valid    (ev_valid),
        .i_ev_idx      (r_didx),
        .i_ev_entry    (r_rd_data),
        .o_fit_hit     (fit_hit),
        .o_pos         (scan_pos),
        .o_stat        (stat)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_req       = in_accept ? i_in_req : r_req;
        n_count     = r_count;
        n_idx       = r_idx;
        n_dv        = 1'b0;
        n_didx      = r_didx;
        n_ins_pos   = r_ins_pos;
        n_ins_start = r_ins_start;
        n_ins_len   = r_ins_len;
        n_del_pos   = r_del_pos;
        n_old_len   = r_old_len;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        scan_init   = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if ((i_in_req.operation == OP_ALLOC) &&
                        (r_count >= CW'(MAX_REGIONS))) begin
                        n_res   = '{result_value: '0, status: ST_TABLE_FULL};
                        n_state = S_DONE;
                    end else begin
                        scan_init = 1'b1;
                        n_idx     = '0;
                        n_mode    = (i_in_req.operation == OP_ALLOC) ? SCAN_FIT
                                                                      : SCAN_LOOKUP;
                        n_state   = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (r_idx < r_count) begin
                    rd_addr = r_idx[IW-1:0];
                    n_idx   = r_idx + 1'b1;
                    n_dv    = 1'b1;
                    n_didx  = r_idx[IW-1:0];
                end
                if (fit_hit) begin
                    // Gap found in front of this entry: open a slot here.
                    n_ins_pos   = r_didx;
                    n_ins_start = stat.cur[DATA_W-1:0];
                    n_ins_len   = r_req.request_size;
                    n_res       = '{result_value: stat.cur[DATA_W-1:0], status: ST_OK};
                    n_idx       = r_count;
                    n_dv        = 1'b0;
                    n_state     = S_SHUP;
                end else if (!r_dv && (r_idx >= r_count)) begin
                    if (r_mode == SCAN_FIT) begin
                        if (stat.tail_ok) begin
                            n_ins_pos   = r_count[IW-1:0];
                            n_ins_start = stat.cur[DATA_W-1:0];
                            n_ins_len   = r_req.request_size;
                            n_res       = '{result_value: stat.cur[DATA_W-1:0],
                                            status: ST_OK};
                            n_idx       = r_count;
                            n_state     = S_SHUP;
                        end else if (r_req.operation == OP_RESIZE) begin
                            // The move failed: put the region back where it was.
                            n_ins_pos   = r_del_pos;
                            n_ins_start = r_req.region_address;
                            n_ins_len   = r_old_len;
                            n_res       = '{result_value: '0, status: ST_NO_SPACE};
                            n_idx       = r_count;
                            n_state     = S_SHUP;
                        end else begin
                            n_res   = '{result_value: '0, status: ST_NO_SPACE};
                            n_state = S_DONE;
                        end
                    end else begin
                        unique case (r_req.operation)
                            OP_QUERY: begin
                                n_res   = '{result_value: stat.space, status: ST_OK};
                                n_state = S_DONE;
                            end
                            OP_RELEASE: begin
                                if (stat.found) begin
                                    n_res     = '{result_value: '0, status: ST_OK};
                                    n_del_pos = scan_pos;
                                    n_idx     = CW'(scan_pos) + 1'b1;
                                    n_state   = S_SHDN;
                                end else begin
                                    n_res   = '{result_value: '0, status: ST_NOT_FOUND};
                                    n_state = S_DONE;
                                end
                            end
                            OP_RESIZE: begin
                                if (!stat.found) begin
                                    n_res   = '{result_value: '0, status: ST_NOT_FOUND};
                                    n_state = S_DONE;
                                end else if (stat.space >= r_req.request_size) begin
                                    wr_en   = 1'b1;
                                    wr_addr = scan_pos;
                                    wr_data = '{start: r_req.region_address,
                                                length: r_req.request_size};
                                    n_res   = '{result_value: r_req.region_address,
                                                status: ST_OK};
                                    n_state = S_DONE;
                                end else begin
                                    n_del_pos = scan_pos;
                                    n_old_len = stat.old_len;
                                    n_idx     = CW'(scan_pos) + 1'b1;
                                    n_state   = S_SHDN;
                                end
                            end
                            OP_ALLOC: begin
                                n_state = S_DONE;
                            end
                            default: begin
                                n_state = S_DONE;
                            end
                        endcase
                    end
                end
            end

            S_SHUP: begin
                // Entries move up one slot, top first; r_idx is the next slot
                // to be filled from below.
                if (r_idx > CW'(r_ins_pos)) begin
                    rd_addr = idx_dec[IW-1:0];
                    n_idx   = idx_dec;
                    n_dv    = 1'b1;
                    n_didx  = idx_dec[IW-1:0];
                end
                if (r_dv) begin
                    wr_en   = 1'b1;
                    wr_addr = IW'(CW'(r_didx) + 1'b1);
                    wr_data = r_rd_data;
                end else if (r_idx <= CW'(r_ins_pos)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_ins_pos;
                    wr_data = '{start: r_ins_start, length: r_ins_len};
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end

            S_SHDN: begin
                if (r_idx < r_count) begin
                    rd_addr = r_idx[IW-1:0];
                    n_idx   = r_idx + 1'b1;
                    n_dv    = 1'b1;
                    n_didx  = r_idx[IW-1:0];
                end
                if (r_dv) begin
                    wr_en   = 1'b1;
                    wr_addr = r_didx - 1'b1;
                    wr_data = r_rd_data;
                end else if (r_idx >= r_count) begin
                    n_count = r_count - 1'b1;
                    if (r_req.operation == OP_RESIZE) begin
                        scan_init = 1'b1;
                        n_idx     = '0;
                        n_mode    = SCAN_FIT;
                        n_state   = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_dv          <= 1'b0;
            r_out_valid   <= 1'b0;
            r_memory_size <= MEMORY_SIZE_RST;
            r_heap_start  <= HEAP_START_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MEMORY_SIZE: r_memory_size <= i_cfg_data;
                    CFG_HEAP_START:  r_heap_start  <= i_cfg_data;
                    default:         r_heap_start  <= r_heap_start;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_req       <= n_req;
        r_idx       <= n_idx;
        r_didx      <= n_didx;
        r_ins_pos   <= n_ins_pos;
        r_ins_start <= n_ins_start;
        r_ins_len   <= n_ins_len;
        r_del_pos   <= n_del_pos;
        r_old_len   <= n_old_len;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule : first_fit_region_allocator_core
`default_nettype wire

### sim/first_fit_region_allocator_core_test.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core_test: self-checking bench of the allocator
// Drives allocate, release, query and resize requests through the valid/stall
// channel and checks every response against a mirror of the region table.
// The limit registers are changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ffra_pkg::*;

    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES  = 7;
    localparam int unsigned TABLE_DEPTH   = MAX_REGIONS_DEF;
    localparam int unsigned SETTLE_CYCLES = 4 * TABLE_DEPTH + 16;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned PHASE_ITEMS   = 60;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_req              i_in_req    = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_rsp              o_out_rsp;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    t_cfg_idx          i_cfg_index = CFG_MEMORY_SIZE;
    logic [DATA_W-1:0] i_cfg_data  = '0;

    // Mirror of the region table and the limit registers.
    logic [DATA_W-1:0] table_start [TABLE_DEPTH];
    logic [DATA_W-1:0] table_len   [TABLE_DEPTH];
    int unsigned       table_count = 0;
    int unsigned       mem_limit   = 32'(MEMORY_SIZE_RST);
    int unsigned       heap_base   = 32'(HEAP_START_RST);

    t_rsp        pending_answers [$];
    int unsigned wrong_answers   = 0;
    bit          steady_sender   = 1'b0;
    bit          steady_receiver = 1'b0;
    bit          hold_off_req    = 1'b0;
    int unsigned stall_left      = 0;
    int unsigned hold_left       = 0;

    first_fit_region_allocator_core #(
        .MAX_REGIONS(TABLE_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_rsp  (o_out_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int lookup_region(input int unsigned addr);
        int          pos;
        int unsigned i;
        pos = -1;
        for (i = 0; i < table_count; i++) begin
            if (pos < 0 && 32'(table_start[i]) == addr) begin
                pos = i;
            end
        end
        return pos;
    endfunction

    function automatic void drop_region(input int unsigned pos);
        int unsigned i;
        for (i = pos; i + 1 < table_count; i++) begin
            table_start[i] = table_start[i + 1];
            table_len[i]   = table_len[i + 1];
        end
        table_count--;
    endfunction

    function automatic void add_region(input int unsigned pos, input int unsigned start,
                                       input int unsigned len);
        int unsigned i;
        for (i = table_count; i > pos; i--) begin
            table_start[i] = table_start[i - 1];
            table_len[i]   = table_len[i - 1];
        end
        table_start[pos] = start[DATA_W-1:0];
        table_len[pos]   = len[DATA_W-1:0];
        table_count++;
    endfunction

    // The cursor only moves up, so a region that lies below it leaves a gap of zero.
    function automatic bit place_first_fit(input int unsigned size,
                                           output int unsigned placed_at);
        int unsigned cursor;
        int unsigned s;
        int unsigned e;
        int unsigned i;
        bit          done;
        cursor    = heap_base;
        done      = 1'b0;
        placed_at = 0;
        for (i = 0; i < table_count && !done; i++) begin
            s = 32'(table_start[i]);
            e = s + 32'(table_len[i]);
            if (s >= cursor && s - cursor >= size) begin
                add_region(i, cursor, size);
                placed_at = cursor;
                done      = 1'b1;
            end else if (e > cursor) begin
                cursor = e;
            end
        end
        if (!done && mem_limit >= cursor && mem_limit - cursor >= size) begin
            add_region(table_count, cursor, size);
            placed_at = cursor;
            done      = 1'b1;
        end
        return done;
    endfunction

    function automatic int unsigned free_bytes_from(input int unsigned addr);
        int unsigned i;
        int unsigned bytes;
        bit          hit;
        if (addr > mem_limit) begin
            return 0;
        end
        bytes = mem_limit - addr;
        hit   = 1'b0;
        for (i = 0; i < table_count; i++) begin
            if (!hit && 32'(table_start[i]) > addr) begin
                bytes = 32'(table_start[i]) - addr;
                hit   = 1'b1;
            end
        end
        return bytes;
    endfunction

    // Applies one request to the mirror and returns the answer the core owes.
    function automatic t_rsp allocator_answer(input t_req req);
        t_rsp        rsp;
        int          pos;
        int unsigned size;
        int unsigned addr;
        int unsigned placed_at;
        int unsigned old_len;
        size             = 32'(req.request_size);
        addr             = 32'(req.region_address);
        rsp.result_value = '0;
        rsp.status       = ST_OK;
        case (req.operation)
            OP_ALLOC: begin
                if (table_count >= TABLE_DEPTH) begin
                    rsp.status = ST_TABLE_FULL;
                end else if (place_first_fit(size, placed_at)) begin
                    rsp.result_value = placed_at[DATA_W-1:0];
                end else begin
                    rsp.status = ST_NO_SPACE;
                end
            end
            OP_RELEASE: begin
                pos = lookup_region(addr);
                if (pos < 0) begin
                    rsp.status = ST_NOT_FOUND;
                end else begin
                    drop_region(pos);
                end
            end
            OP_QUERY: begin
                rsp.result_value = DATA_W'(free_bytes_from(addr));
            end
            default: begin
                pos = lookup_region(addr);
                if (pos < 0) begin
                    rsp.status = ST_NOT_FOUND;
                end else if (free_bytes_from(addr) >= size) begin
                    table_len[pos]   = size[DATA_W-1:0];
                    rsp.result_value = addr[DATA_W-1:0];
                end else begin
                    // The region's own space is free while it looks for a new home.
                    old_len = 32'(table_len[pos]);
                    drop_region(pos);
                    if (place_first_fit(size, placed_at)) begin
                        rsp.result_value = placed_at[DATA_W-1:0];
                    end else begin
                        add_region(pos, addr, old_len);
                        rsp.status = ST_NO_SPACE;
                    end
                end
            end
        endcase
        return rsp;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_sender || roll < 45) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_size();
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(0, 99);
        span = (mem_limit > heap_base) ? mem_limit - heap_base : 64;
        if (roll < 8) begin
            return 0;
        end
        if (roll < 16) begin
            return $urandom_range(0, 16'hFFFF);
        end
        return $urandom_range(1, span / 5 + 1);
    endfunction

    // Mostly addresses of live regions, so release and resize get past the lookup.
    function automatic int unsigned pick_address();
        int unsigned roll;
        int unsigned slot;
        roll = $urandom_range(0, 99);
        if (table_count != 0 && roll < 80) begin
            slot = $urandom_range(0, table_count - 1);
            if (roll < 68) begin
                return 32'(table_start[slot]);
            end
            return (32'(table_start[slot]) + 32'(table_len[slot])) & 32'hFFFF;
        end
        if (roll < 88) begin
            return heap_base;
        end
        return $urandom_range(0, 16'hFFFF);
    endfunction

    task automatic send_request(input t_op op, input int unsigned size,
                                input int unsigned addr);
        t_req        req;
        int unsigned gap;
        req.operation      = op;
        req.request_size   = size[DATA_W-1:0];
        req.region_address = addr[DATA_W-1:0];
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_answers.push_back(allocator_answer(req));
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_request();
        int unsigned roll;
        t_op         op;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            op = OP_ALLOC;
        end else if (roll < 57) begin
            op = OP_RELEASE;
        end else if (roll < 75) begin
            op = OP_QUERY;
        end else begin
            op = OP_RESIZE;
        end
        send_request(op, pick_size(), pick_address());
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input int unsigned data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_MEMORY_SIZE) begin
            mem_limit = data & 16'hFFFF;
        end else begin
            heap_base = data & 16'hFFFF;
        end
    endtask

    task automatic set_limits(input int unsigned msize, input int unsigned hstart);
        wait_for_results();
        write_register(CFG_MEMORY_SIZE, msize);
        write_register(CFG_HEAP_START, hstart);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_ops();
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 0, 16'hFFFF);
        send_request(OP_RELEASE, 0, 32'(HEAP_START_RST));
        send_request(OP_RESIZE, 100, 32'(HEAP_START_RST));
        send_request(OP_ALLOC, 16'hFFFF, 0);
        send_request(OP_ALLOC, 200, 0);
        send_request(OP_QUERY, 0, 300);
        send_request(OP_QUERY, 0, 16'hFFFF);
        send_request(OP_RELEASE, 0, 1000);
        send_request(OP_RESIZE, 500, 32'(HEAP_START_RST));
        send_request(OP_RESIZE, 16'hFFFF, 32'(table_start[table_count - 1]));
        send_request(OP_RESIZE, 10, 4242);
        send_request(OP_QUERY, 0, 0);
    endtask

    task automatic test_table_full();
        while (table_count < TABLE_DEPTH) begin
            send_request(OP_ALLOC, $urandom_range(1, 40), $urandom_range(0, 16'hFFFF));
        end
        send_request(OP_ALLOC, 0, 0);
    endtask

    task automatic test_limit_changes();
        // Every live region now sits below the new heap start.
        set_limits(32'(MEMORY_SIZE_RST), 2000);
        send_request(OP_RELEASE, 0, 32'(table_start[0]));
        send_request(OP_ALLOC, 10, 0);
        // Heap start beyond the end of storage leaves no tail at all.
        set_limits(1000, 2000);
        send_request(OP_RELEASE, 0, 32'(table_start[1]));
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_QUERY, 0, 1001);
        send_request(OP_QUERY, 0, 1000);
        set_limits(16'hFFFF, 0);
        send_request(OP_ALLOC, 16'hFFFF, 0);
        send_request(OP_ALLOC, 50, 0);
        send_request(OP_QUERY, 0, 16'hFFFF);
    endtask

    task automatic test_backpressure();
        set_limits(32'(MEMORY_SIZE_RST), 32'(HEAP_START_RST));
        steady_sender = 1'b1;
        hold_off_req  = 1'b1;
        repeat (12) random_request();
        steady_sender = 1'b0;
        wait_for_results();
        repeat (10) random_request();
    endtask

    task automatic test_random_mix();
        set_limits(32'(MEMORY_SIZE_RST), 32'(HEAP_START_RST));
        repeat (PHASE_ITEMS) random_request();
        set_limits(16'hFFFF, 0);
        repeat (PHASE_ITEMS) random_request();
        set_limits(1000, 600);
        repeat (PHASE_ITEMS) random_request();
        set_limits(0, 0);
        repeat (PHASE_ITEMS) random_request();
        set_limits(16'hFFFF, 16'hFFFF);
        repeat (PHASE_ITEMS) random_request();
        set_limits(2048, 4000);
        repeat (PHASE_ITEMS) random_request();
        // A stretch with neither side idling.
        set_limits($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
        steady_sender   = 1'b1;
        steady_receiver = 1'b1;
        repeat (PHASE_ITEMS) random_request();
        steady_sender   = 1'b0;
        steady_receiver = 1'b0;
        set_limits(32'(MEMORY_SIZE_RST), 32'(HEAP_START_RST));
        repeat (PHASE_ITEMS) random_request();
    endtask

    // Response side: checks each accepted response, then decides the next stall.
    always @(posedge i_clk) begin : response_side
        t_rsp        want;
        int unsigned roll;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: response with no request outstanding, value %0d status %0d",
                         $time, o_out_rsp.result_value, o_out_rsp.status);
                wrong_answers++;
            end else begin
                want = pending_answers.pop_front();
                if (o_out_rsp.result_value !== want.result_value) begin
                    $display("%0t: result_value expected %0d, got %0d",
                             $time, want.result_value, o_out_rsp.result_value);
                    wrong_answers++;
                end
                if (o_out_rsp.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, o_out_rsp.status);
                    wrong_answers++;
                end
            end
        end
        if (hold_off_req) begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (steady_receiver) begin
            i_out_stall <= 1'b0;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b1;
                stall_left = (roll < 93) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ops();
        test_table_full();
        test_limit_changes();
        test_backpressure();
        test_random_mix();
        wait_for_results();
        if (wrong_answers == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/ffra_pkg.sv
rtl/core/ffra_scan.sv
rtl/core/first_fit_region_allocator_core.sv
sim/first_fit_region_allocator_core_test.sv
